@@ sv/vsae_pkg.sv @@
// Shared types, register indexes and fixed thresholds of the vital sign alarm escalator.
package vsae_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SPO2_CRIT_BELOW = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPO2_WARN_BELOW = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEART_CRIT_LOW  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEART_CRIT_HIGH = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HEART_WARN_LOW  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HEART_WARN_HIGH = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CRIT_LOW   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CRIT_HIGH  = 4'd7;

    // Register reset values.
    localparam logic [6:0]  RST_SPO2_CRIT_BELOW = 7'd85;
    localparam logic [6:0]  RST_SPO2_WARN_BELOW = 7'd92;
    localparam logic [8:0]  RST_HEART_CRIT_LOW  = 9'd40;
    localparam logic [8:0]  RST_HEART_CRIT_HIGH = 9'd150;
    localparam logic [8:0]  RST_HEART_WARN_LOW  = 9'd45;
    localparam logic [8:0]  RST_HEART_WARN_HIGH = 9'd120;
    localparam logic [15:0] RST_TEMP_CRIT_LOW   = 16'd3500;
    localparam logic [15:0] RST_TEMP_CRIT_HIGH  = 16'd4000;

    // Fixed warning limits: 35.50 C to 38.50 C, systolic 90 to 160 mmHg.
    localparam logic signed [15:0] TEMP_WARN_LOW  = 16'sd3550;
    localparam logic signed [15:0] TEMP_WARN_HIGH = 16'sd3850;
    localparam logic [8:0]         SYS_HIGH       = 9'd160;
    localparam logic [8:0]         SYS_LOW        = 9'd90;

    // Impact limit: 3.5 g squared with 65536 units per g squared.
    localparam int MAG_W = 32;
    localparam logic [MAG_W-1:0] FALL_SQ_LIMIT = 32'd802816;

    // Anomaly tally.
    localparam int TALLY_W = 8;
    localparam logic [TALLY_W-1:0] TALLY_MAX   = 8'd255;
    localparam logic [TALLY_W-1:0] TALLY_EXTEND = 8'd2;

    typedef enum logic [1:0] {
        GRADE_NORMAL    = 2'd0,
        GRADE_WARNING   = 2'd1,
        GRADE_CRITICAL  = 2'd2,
        GRADE_EMERGENCY = 2'd3
    } grade_t;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_EXTENDED  = 2'd1,
        MODE_EMERGENCY = 2'd2
    } mode_t;

    // Threshold register set.
    typedef struct packed {
        logic [6:0]  spo2_crit_below;
        logic [6:0]  spo2_warn_below;
        logic [8:0]  heart_crit_low;
        logic [8:0]  heart_crit_high;
        logic [8:0]  heart_warn_low;
        logic [8:0]  heart_warn_high;
        logic [15:0] temp_crit_low;
        logic [15:0] temp_crit_high;
    } cfg_t;

    // Outcome of grading one measurement set.
    typedef struct packed {
        grade_t grade;
        logic   fall;
    } eval_t;

endpackage

@@ sv/vsae_cfg_regs.sv @@
// Threshold configuration register file.
module vsae_cfg_regs
    import vsae_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are taken in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index; writes beyond the list are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPO2_CRIT_BELOW: cfg_next.spo2_crit_below = cfg_data[6:0];
                REG_SPO2_WARN_BELOW: cfg_next.spo2_warn_below = cfg_data[6:0];
                REG_HEART_CRIT_LOW:  cfg_next.heart_crit_low  = cfg_data[8:0];
                REG_HEART_CRIT_HIGH: cfg_next.heart_crit_high = cfg_data[8:0];
                REG_HEART_WARN_LOW:  cfg_next.heart_warn_low  = cfg_data[8:0];
                REG_HEART_WARN_HIGH: cfg_next.heart_warn_high = cfg_data[8:0];
                REG_TEMP_CRIT_LOW:   cfg_next.temp_crit_low   = cfg_data[15:0];
                REG_TEMP_CRIT_HIGH:  cfg_next.temp_crit_high  = cfg_data[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spo2_crit_below <= RST_SPO2_CRIT_BELOW;
            cfg_reg.spo2_warn_below <= RST_SPO2_WARN_BELOW;
            cfg_reg.heart_crit_low  <= RST_HEART_CRIT_LOW;
            cfg_reg.heart_crit_high <= RST_HEART_CRIT_HIGH;
            cfg_reg.heart_warn_low  <= RST_HEART_WARN_LOW;
            cfg_reg.heart_warn_high <= RST_HEART_WARN_HIGH;
            cfg_reg.temp_crit_low   <= RST_TEMP_CRIT_LOW;
            cfg_reg.temp_crit_high  <= RST_TEMP_CRIT_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/vsae_grader.sv @@
// Range checks, fall detection and status grading of one measurement set.
module vsae_grader
    import vsae_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [6:0]         oxygen_saturation,
    input  logic [8:0]         pulse_rate,
    input  logic [8:0]         systolic_pressure,
    input  logic signed [15:0] body_temp,
    input  logic signed [15:0] accel_x_axis,
    input  logic signed [15:0] accel_y_axis,
    input  logic signed [15:0] accel_z_axis,
    output eval_t              eval
);

    logic signed [31:0] sq_x;
    logic signed [31:0] sq_y;
    logic signed [31:0] sq_z;
    logic [MAG_W-1:0]   mag2;
    logic               fall;
    logic               spo2_crit;
    logic               spo2_warn;
    logic               heart_crit;
    logic               heart_warn;
    logic               temp_crit;
    logic               temp_warn;
    logic               sys_warn;
    logic [2:0]         warn_count;

    // Squared magnitude; each square is non-negative and at most 2^30.
    assign sq_x = 32'(accel_x_axis) * 32'(accel_x_axis);
    assign sq_y = 32'(accel_y_axis) * 32'(accel_y_axis);
    assign sq_z = 32'(accel_z_axis) * 32'(accel_z_axis);
    assign mag2 = {1'b0, sq_x[30:0]} + {1'b0, sq_y[30:0]} + {1'b0, sq_z[30:0]};
    assign fall = (mag2 > FALL_SQ_LIMIT);

    // Two-level checks: a warning counts only when the critical check passes.
    assign spo2_crit  = (oxygen_saturation < cfg.spo2_crit_below);
    assign spo2_warn  = !spo2_crit && (oxygen_saturation < cfg.spo2_warn_below);
    assign heart_crit = (pulse_rate < cfg.heart_crit_low) || (pulse_rate > cfg.heart_crit_high);
    assign heart_warn = !heart_crit
                        && ((pulse_rate < cfg.heart_warn_low)
                            || (pulse_rate > cfg.heart_warn_high));
    assign temp_crit  = (body_temp < $signed(cfg.temp_crit_low))
                        || (body_temp > $signed(cfg.temp_crit_high));
    assign temp_warn  = !temp_crit
                        && ((body_temp < TEMP_WARN_LOW) || (body_temp > TEMP_WARN_HIGH));
    assign sys_warn   = (systolic_pressure > SYS_HIGH) || (systolic_pressure < SYS_LOW);

    assign warn_count = 3'({2'b00, spo2_warn}) + 3'({2'b00, heart_warn})
                      + 3'({2'b00, temp_warn}) + 3'({2'b00, sys_warn})
                      + 3'({2'b00, fall});

    // Grade: any critical flag or a fall is an emergency; two or more warnings are critical, one is a warning.
    always_comb
    begin
        eval.fall = fall;
        if (spo2_crit || heart_crit || temp_crit || fall)
        begin
            eval.grade = GRADE_EMERGENCY;
        end
        else if (warn_count >= 3'd2)
        begin
            eval.grade = GRADE_CRITICAL;
        end
        else if (warn_count != 3'd0)
        begin
            eval.grade = GRADE_WARNING;
        end
        else
        begin
            eval.grade = GRADE_NORMAL;
        end
    end

endmodule

@@ sv/vsae_escalate.sv @@
// Escalation state (tally, alert latch, mode) and the result register.
module vsae_escalate
    import vsae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  eval_t      eval,
    output logic [1:0] health_grade,
    output logic [1:0] watch_mode,
    output logic       send_report,
    output logic       report_urgent,
    output logic       fall_flag
);

    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] tally_next;
    logic               latch_reg;
    logic               latch_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic               report_next;
    logic               urgent_next;

    logic [1:0]         grade_out_reg;
    mode_t              mode_out_reg;
    logic               report_out_reg;
    logic               urgent_out_reg;
    logic               fall_out_reg;

    // Next escalation state for the item being graded.
    always_comb
    begin
        tally_next  = tally_reg;
        latch_next  = latch_reg;
        mode_next   = mode_reg;
        report_next = 1'b0;
        urgent_next = 1'b0;
        case (eval.grade)
            GRADE_NORMAL:
            begin
                mode_next  = MODE_NORMAL;
                tally_next = '0;
                latch_next = 1'b0;
            end
            GRADE_WARNING:
            begin
                if (tally_reg != TALLY_MAX)
                begin
                    tally_next = tally_reg + TALLY_W'(1);
                end
                if (tally_next >= TALLY_EXTEND)
                begin
                    mode_next = MODE_EXTENDED;
                end
            end
            GRADE_CRITICAL:
            begin
                mode_next   = MODE_EXTENDED;
                report_next = 1'b1;
            end
            default:
            begin
                mode_next = MODE_EMERGENCY;
                if (!latch_reg)
                begin
                    report_next = 1'b1;
                    urgent_next = 1'b1;
                    latch_next  = 1'b1;
                end
            end
        endcase
    end

    // Escalation state advances once per graded item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            latch_reg <= 1'b0;
            mode_reg  <= MODE_NORMAL;
        end
        else if (load)
        begin
            tally_reg <= tally_next;
            latch_reg <= latch_next;
            mode_reg  <= mode_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grade_out_reg  <= eval.grade;
            mode_out_reg   <= mode_next;
            report_out_reg <= report_next;
            urgent_out_reg <= urgent_next;
            fall_out_reg   <= eval.fall;
        end
    end

    assign health_grade  = grade_out_reg;
    assign watch_mode    = mode_out_reg;
    assign send_report   = report_out_reg;
    assign report_urgent = urgent_out_reg;
    assign fall_flag     = fall_out_reg;

endmodule

@@ sv/vital_sign_alarm_escalator.sv @@
// Top level of the vital sign alarm escalator: input register, grading and result register.
//
// The block takes one measurement set per clock cycle and returns one result item for
// each. An accepted item is held in the input register, and from there the three
// acceleration squares, the threshold compares and the escalation update are loaded
// into the result register, which drives out_valid; the result is taken while
// out_stall is low. With out_stall low the block sustains one item per
// cycle. While a result waits under out_stall, one more item can be taken into the input
// register; in_stall rises only when both registers are full and out_stall is high.
// Threshold registers are written through the cfg channel, which is always ready; writes
// to an index beyond the eight registers are ignored. Configuration should change only
// while no item is in flight.
module vital_sign_alarm_escalator
    import vsae_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [6:0]             oxygen_saturation,
    input  logic [8:0]             pulse_rate,
    input  logic [8:0]             systolic_pressure,
    input  logic signed [15:0]     body_temp,
    input  logic signed [15:0]     accel_x_axis,
    input  logic signed [15:0]     accel_y_axis,
    input  logic signed [15:0]     accel_z_axis,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             health_grade,
    output logic [1:0]             watch_mode,
    output logic                   send_report,
    output logic                   report_urgent,
    output logic                   fall_flag,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t               cfg;
    eval_t              eval;

    logic               in_full_reg;
    logic               out_full_reg;
    logic               res_load;
    logic               in_take;

    logic [6:0]         spo2_reg;
    logic [8:0]         pulse_reg;
    logic [8:0]         sys_reg;
    logic signed [15:0] temp_reg;
    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;

    // Handshake: the result register loads when empty or being drained.
    assign res_load  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall  = in_full_reg && !res_load;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_full_reg;

    // Occupancy of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_take || (in_full_reg && !res_load);
            if (res_load)
            begin
                out_full_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            spo2_reg  <= oxygen_saturation;
            pulse_reg <= pulse_rate;
            sys_reg   <= systolic_pressure;
            temp_reg  <= body_temp;
            ax_reg    <= accel_x_axis;
            ay_reg    <= accel_y_axis;
            az_reg    <= accel_z_axis;
        end
    end

    vsae_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vsae_grader u_grader (
        .cfg               (cfg),
        .oxygen_saturation (spo2_reg),
        .pulse_rate        (pulse_reg),
        .systolic_pressure (sys_reg),
        .body_temp         (temp_reg),
        .accel_x_axis      (ax_reg),
        .accel_y_axis      (ay_reg),
        .accel_z_axis      (az_reg),
        .eval              (eval)
    );

    vsae_escalate u_escalate (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .eval          (eval),
        .health_grade  (health_grade),
        .watch_mode    (watch_mode),
        .send_report   (send_report),
        .report_urgent (report_urgent),
        .fall_flag     (fall_flag)
    );

endmodule
